// ===== design/bb_pkg.sv =====
// ----------------------------------------------------------------------------
// bb_pkg
// shared types and constants for the bollinger band block
// ----------------------------------------------------------------------------
package bb_pkg;

   localparam int IN_WIDTH   = 24;
   localparam int BAND_WIDTH = 26;

   typedef struct packed {
      logic [IN_WIDTH-1:0] close_price;
      logic                series_start;
   } req_payload_type;

   typedef struct packed {
      logic signed [BAND_WIDTH-1:0] band_value;
      logic                         band_valid;
   } rsp_payload_type;

   // register indexes
   localparam logic [1:0] REG_WINDOW_LENGTH = 2'd0;
   localparam logic [1:0] REG_DEV_MULT      = 2'd1;
   localparam logic [1:0] REG_BAND_SELECT   = 2'd2;

   localparam logic [8:0]  WINDOW_RESET = 9'd20;
   localparam logic [11:0] MULT_RESET   = 12'd512;

   // datapath commands
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_LOAD,      // take input, start ring read
      CMD_UPDATE,    // update sums, write ring
      CMD_SQ_START,  // load squaring of sum
      CMD_SQ_STEP,
      CMD_DIV_START, // sum^2/n, quotient and remainder
      CMD_DIV_STEP,
      CMD_VAR_START, // (s2 - c)/n
      CMD_VAR_STEP,
      CMD_SQRT_START,
      CMD_SQRT_STEP,
      CMD_BAND,
      CMD_OUT
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic sq_done;
      logic sqrt_done;
      logic full;
   } status_type;

endpackage

// ===== design/bollinger_band.sv =====
// ----------------------------------------------------------------------------
// bollinger_band
// band level mean +/- k*sigma over a sliding window of closing prices
// ----------------------------------------------------------------------------
// sequence: while the window fills, the result follows the update directly; once
// full, the update is followed by the squarer, two divider passes and the root
// steps with the mean alongside, plus state hand-offs; one transaction at a time,
// the next accepted once the result is loaded into the output register
// synchronous active-high reset clears sums, counts and registers
// the price ring needs no clearing, only written entries are read
module bollinger_band
   import bb_pkg::*;
#(
   parameter int MAX_WINDOW  = 256,
   parameter int PRICE_WIDTH = 24
)(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [31:0]     csr_data
);

   // configuration registers
   logic [8:0]  window_ff;
   logic [11:0] mult_ff;
   logic        sel_ff;
   logic        cfg_clear;

   assign csr_ready = 1'b1;
   assign cfg_clear = csr_valid && csr_index == REG_WINDOW_LENGTH;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         mult_ff   <= MULT_RESET;
         sel_ff    <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            REG_WINDOW_LENGTH: window_ff <= csr_data[8:0];
            REG_DEV_MULT:      mult_ff   <= csr_data[11:0];
            REG_BAND_SELECT:   sel_ff    <= csr_data[0];
            default:           ;
         endcase
      end
   end

   cmd_type         cmd;
   status_type      status;
   logic            out_load;
   rsp_payload_type out_data;

   // output register, held until the consumer takes the transaction
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   logic            out_busy;

   assign out_busy = rsp_valid_ff && rsp_stall;

   bb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_busy  (out_busy),
      .status    (status),
      .cmd       (cmd)
   );

   bb_datapath #(
      .MAX_WINDOW  (MAX_WINDOW),
      .PRICE_WIDTH (PRICE_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_data      (req_data),
      .cfg_clear     (cfg_clear),
      .window_length (window_ff),
      .dev_mult      (mult_ff),
      .band_sel      (sel_ff),
      .out_load      (out_load),
      .out_data      (out_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) rsp_data_ff <= out_data;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/bb_ctrl.sv =====
// ----------------------------------------------------------------------------
// bb_ctrl
// sequencer for one price transaction through the datapath
// ----------------------------------------------------------------------------
module bb_ctrl
   import bb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       out_busy,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_UPDATE, S_SQ, S_DIV0, S_DIV, S_VAR0, S_VAR, S_SQRT0, S_SQRT, S_BAND, S_OUT
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd = CMD_LOAD;
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd = CMD_UPDATE;
            state_in = S_SQ;
         end
         S_SQ: begin
            if (!status.full) begin
               state_in = S_OUT;
            end else begin
               cmd = CMD_SQ_START;
               state_in = S_DIV0;
            end
         end
         S_DIV0: begin
            cmd = CMD_SQ_STEP;
            if (status.sq_done) state_in = S_DIV;
         end
         S_DIV: begin
            cmd = CMD_DIV_START;
            state_in = S_VAR0;
         end
         S_VAR0: begin
            cmd = CMD_DIV_STEP;
            if (status.div_done) state_in = S_VAR;
         end
         S_VAR: begin
            cmd = CMD_VAR_START;
            state_in = S_SQRT0;
         end
         S_SQRT0: begin
            cmd = CMD_VAR_STEP;
            if (status.div_done) state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd = CMD_SQRT_START;
            state_in = S_BAND;
         end
         S_BAND: begin
            cmd = CMD_SQRT_STEP;
            if (status.sqrt_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (!out_busy) begin
               cmd = status.full ? CMD_BAND : CMD_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ===== design/bb_datapath.sv =====
// ----------------------------------------------------------------------------
// bb_datapath
// price ring, running sums, shared divider, squarer and root unit
// ----------------------------------------------------------------------------
module bb_datapath
   import bb_pkg::*;
#(
   parameter int MAX_WINDOW  = 256,
   parameter int PRICE_WIDTH = 24
)(
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   output status_type      status,
   input  req_payload_type req_data,
   input  logic            cfg_clear,
   input  logic [8:0]      window_length,
   input  logic [11:0]     dev_mult,
   input  logic            band_sel,
   output logic            out_load,
   output rsp_payload_type out_data
);

   localparam int AW   = $clog2(MAX_WINDOW);
   localparam int CW   = $clog2(MAX_WINDOW + 1);
   localparam int SW   = PRICE_WIDTH + CW;          // sum width
   localparam int QW   = 2 * PRICE_WIDTH + CW;      // square sum width
   localparam int PW   = 2 * SW;                    // sum squared width
   localparam int NW   = CW;                        // divisor width
   localparam int DCW  = $clog2(PW + 1);
   localparam int RW   = SW;                        // root width, matches the mean pass
   localparam int RCW  = $clog2(RW + 1);
   localparam int SQCW = $clog2(SW + 1);

   // effective window length
   logic [NW-1:0] n_eff;
   always_comb begin
      if (window_length == '0)
         n_eff = NW'(1);
      else if ({23'd0, window_length} > MAX_WINDOW)
         n_eff = NW'(MAX_WINDOW);
      else
         n_eff = NW'(window_length);
   end

   logic [PRICE_WIDTH-1:0] ring [MAX_WINDOW];
   logic [PRICE_WIDTH-1:0] old_ff, price_ff;
   logic [AW-1:0]          slot_ff;
   logic [CW-1:0]          fill_ff;
   logic [SW-1:0]          sum_ff;
   logic [QW-1:0]          sq_sum_ff;
   logic [AW-1:0]          slot_cur;
   logic [AW-1:0]          slot_in_rd;

   assign slot_cur = ({{(32-AW){1'b0}}, slot_ff} >= {{(32-NW){1'b0}}, n_eff}) ? '0 : slot_ff;
   assign slot_in_rd = req_data.series_start ? '0 : slot_cur;

   always_ff @(posedge clock) begin
      if (cmd == CMD_LOAD) begin
         old_ff   <= ring[slot_in_rd];
         price_ff <= req_data.close_price[PRICE_WIDTH-1:0];
      end
      if (cmd == CMD_UPDATE) ring[slot_cur] <= price_ff;
   end

   logic start_clear;
   assign start_clear = cmd == CMD_LOAD && req_data.series_start;

   logic [2*PRICE_WIDTH-1:0] old_sq, new_sq;
   assign old_sq = old_ff * old_ff;
   assign new_sq = price_ff * price_ff;

   always_ff @(posedge clock) begin
      if (reset || cfg_clear || start_clear) begin
         slot_ff   <= '0;
         fill_ff   <= '0;
         sum_ff    <= '0;
         sq_sum_ff <= '0;
      end else if (cmd == CMD_UPDATE) begin
         if (fill_ff >= CW'(n_eff)) begin
            sum_ff    <= sum_ff - SW'(old_ff) + SW'(price_ff);
            sq_sum_ff <= sq_sum_ff - QW'(old_sq) + QW'(new_sq);
         end else begin
            sum_ff    <= sum_ff + SW'(price_ff);
            sq_sum_ff <= sq_sum_ff + QW'(new_sq);
            fill_ff   <= fill_ff + 1'b1;
         end
         slot_ff <= ({1'b0, slot_cur} + 1'b1 >= (AW+1)'(n_eff)) ? '0 : slot_cur + 1'b1;
      end
   end

   assign status.full = fill_ff >= CW'(n_eff);

   // shift-add squarer for sum^2, one bit per cycle
   logic [PW-1:0]   sqr_acc_ff;
   logic [SW-1:0]   sqr_m_ff;
   logic [SQCW-1:0] sqr_cnt_ff;
   always_ff @(posedge clock) begin
      if (cmd == CMD_SQ_START) begin
         sqr_acc_ff <= '0;
         sqr_m_ff   <= sum_ff;
         sqr_cnt_ff <= SQCW'(SW);
      end else if (cmd == CMD_SQ_STEP && sqr_cnt_ff != '0) begin
         sqr_acc_ff <= (sqr_acc_ff << 1) + (sqr_m_ff[SW-1] ? PW'(sum_ff) : '0);
         sqr_m_ff   <= sqr_m_ff << 1;
         sqr_cnt_ff <= sqr_cnt_ff - 1'b1;
      end
   end
   assign status.sq_done = (sqr_cnt_ff == SQCW'(1));

   // restoring divider shared by sum^2/n and the variance
   logic [PW-1:0]  dq_ff;
   logic [NW-1:0]  drem_ff;
   logic [DCW-1:0] dcnt_ff;
   logic [NW:0]    dtrial;
   logic [PW:0]    var_diff;
   logic [QW-1:0]  var_num;

   assign dtrial   = {drem_ff, dq_ff[PW-1]};
   // s2 - ceil(sum^2/n) in one subtract, the remainder acting as borrow
   assign var_diff = {1'b0, PW'(sq_sum_ff)} - {1'b0, dq_ff} - (PW+1)'(drem_ff != '0);
   assign var_num  = var_diff[PW] ? '0 : var_diff[QW-1:0];

   always_ff @(posedge clock) begin
      if (cmd == CMD_DIV_START) begin
         dq_ff   <= sqr_acc_ff;
         drem_ff <= '0;
         dcnt_ff <= DCW'(PW);
      end else if (cmd == CMD_VAR_START) begin
         dq_ff     <= PW'(var_num);
         drem_ff   <= '0;
         dcnt_ff   <= DCW'(PW);
      end else if ((cmd == CMD_DIV_STEP || cmd == CMD_VAR_STEP) && dcnt_ff != '0) begin
         if (dtrial >= {1'b0, n_eff}) begin
            drem_ff <= NW'(dtrial - {1'b0, n_eff});
            dq_ff   <= {dq_ff[PW-2:0], 1'b1};
         end else begin
            drem_ff <= dtrial[NW-1:0];
            dq_ff   <= {dq_ff[PW-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff - 1'b1;
      end
   end
   assign status.div_done = (dcnt_ff == DCW'(1));

   // the mean is not taken from the shared divider: floor(sum/n) comes from
   // a separate radix-2 pass over the sum in the root phase
   logic [SW-1:0]  mq_ff;
   logic [NW-1:0]  mrem_ff;
   logic [NW:0]    mtrial;
   assign mtrial = {mrem_ff, mq_ff[SW-1]};

   // bitwise integer square root, two radicand bits per cycle
   logic [2*RW-1:0] rv_ff;
   logic [RW+1:0]   rrem_ff;
   logic [RW-1:0]   rroot_ff;
   logic [RCW-1:0]  rcnt_ff;
   logic [RW+1:0]   rtrial;
   logic [RW+1:0]   rshift;
   assign rshift = {rrem_ff[RW-1:0], rv_ff[2*RW-1 -: 2]};
   assign rtrial = {rroot_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd == CMD_SQRT_START) begin
         rv_ff    <= (2*RW)'(dq_ff);
         rrem_ff  <= '0;
         rroot_ff <= '0;
         rcnt_ff  <= RCW'(RW);
         mq_ff    <= sum_ff;
         mrem_ff  <= '0;
      end else if (cmd == CMD_SQRT_STEP && rcnt_ff != '0) begin
         rv_ff <= rv_ff << 2;
         if (rshift >= rtrial) begin
            rrem_ff  <= rshift - rtrial;
            rroot_ff <= {rroot_ff[RW-2:0], 1'b1};
         end else begin
            rrem_ff  <= rshift;
            rroot_ff <= {rroot_ff[RW-2:0], 1'b0};
         end
         rcnt_ff <= rcnt_ff - 1'b1;
      end
      if (cmd == CMD_SQRT_STEP) begin
         if (mtrial >= {1'b0, n_eff}) begin
            mrem_ff <= NW'(mtrial - {1'b0, n_eff});
            mq_ff   <= {mq_ff[SW-2:0], 1'b1};
         end else begin
            mrem_ff <= mtrial[NW-1:0];
            mq_ff   <= {mq_ff[SW-2:0], 1'b0};
         end
      end
   end
   // root and mean both take SW steps
   assign status.sqrt_done = (rcnt_ff == RCW'(1));

   // band formation
   localparam int BW = RW + 14 + 2;
   logic [RW+11:0]       spread;
   logic signed [BW+SW:0] exact, floored;
   assign spread  = dev_mult * rroot_ff;
   assign exact   = band_sel
      ? $signed({1'b0, (BW+SW)'(mq_ff) << 8}) + $signed({1'b0, (BW+SW)'(spread)})
      : $signed({1'b0, (BW+SW)'(mq_ff) << 8}) - $signed({1'b0, (BW+SW)'(spread)});
   assign floored = exact >>> 8;

   logic signed [BAND_WIDTH-1:0] sat;
   always_comb begin
      if (floored > $signed((BW+SW+1)'(33554431)))
         sat = {1'b0, {(BAND_WIDTH-1){1'b1}}};
      else if (floored < -$signed((BW+SW+1)'(33554432)))
         sat = {1'b1, {(BAND_WIDTH-1){1'b0}}};
      else
         sat = BAND_WIDTH'(floored);
   end

   assign out_load = (cmd == CMD_BAND) || (cmd == CMD_OUT);
   assign out_data.band_value = (cmd == CMD_BAND) ? sat : '0;
   assign out_data.band_valid = (cmd == CMD_BAND);

endmodule
